@@ rtl/core/task_time_load_profiler_unit_macros.svh @@
// assertion macros for the load profiler checker
`ifndef TASK_TIME_LOAD_PROFILER_UNIT_MACROS_SVH
`define TASK_TIME_LOAD_PROFILER_UNIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define TTLP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttlp assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define TTLP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ttlp assertion failed");

`endif

@@ rtl/core/ttlp_pkg.sv @@
package ttlp_pkg;

    localparam int WHOLE_W     = 7;
    localparam int TENTHS_W    = 4;
    localparam int DIGIT_W     = 4;
    localparam int TASK_W      = 2;
    localparam int FUNC_W      = 2;
    localparam int STAMP_W     = 32;
    localparam int DIGIT_STEPS = 10;

    localparam logic [WHOLE_W-1:0]  WHOLE_FULL = 7'd100;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENTER,
        FUNC_EXIT,
        FUNC_WIN_END,
        FUNC_REPORT
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_SHARE,
        ST_WAIT
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_PREP,
        DV_STEP
    } t_dv_state;

    typedef struct packed {
        logic                done;
        logic [WHOLE_W-1:0]  whole;
        logic [TENTHS_W-1:0] tenths;
    } t_div_stat;

endpackage

@@ rtl/core/ttlp_div.sv @@
module ttlp_div
    import ttlp_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_t,
    input  logic [W-1:0] i_total,
    output t_div_stat    o_stat
);

    t_dv_state r_state, n_state;
    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_total, n_total;
    logic [W-1:0] r_diff, n_diff;
    logic [W-1:0] r_acc, n_acc;
    logic [3:0] r_cnt, n_cnt;
    logic [1:0] r_digit, n_digit;
    logic [DIGIT_W-1:0] r_d, n_d;
    logic [DIGIT_W-1:0] r_d0, n_d0;
    logic [DIGIT_W-1:0] r_d1, n_d1;
    logic [WHOLE_W-1:0] r_whole, n_whole;
    logic [TENTHS_W-1:0] r_tenths, n_tenths;
    logic r_done, n_done;

    // shared subtract / compare unit
    logic [W-1:0] sub_a, sub_b;
    logic [W:0] sub;
    logic borrow;
    logic [W-1:0] acc_step;
    logic [DIGIT_W-1:0] d_step;

    assign sub = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = sub[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_total  <= n_total;
        r_diff   <= n_diff;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_digit  <= n_digit;
        r_d      <= n_d;
        r_d0     <= n_d0;
        r_d1     <= n_d1;
        r_whole  <= n_whole;
        r_tenths <= n_tenths;
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_total  = r_total;
        n_diff   = r_diff;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_digit  = r_digit;
        n_d      = r_d;
        n_d0     = r_d0;
        n_d1     = r_d1;
        n_whole  = r_whole;
        n_tenths = r_tenths;
        n_done   = 1'b0;
        sub_a    = r_acc;
        sub_b    = r_diff;
        acc_step = r_acc + r_rem;
        d_step   = r_d;
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_rem   = i_t;
                    n_total = i_total;
                    n_state = DV_CHECK;
                end
            end
            DV_CHECK: begin
                sub_a = r_rem;
                sub_b = r_total;
                if (r_total == '0) begin
                    n_whole  = '0;
                    n_tenths = '0;
                    n_done   = 1'b1;
                    n_state  = DV_IDLE;
                end else if (!borrow) begin
                    // time not below total: clamp to full share
                    n_whole  = WHOLE_FULL;
                    n_tenths = '0;
                    n_done   = 1'b1;
                    n_state  = DV_IDLE;
                end else begin
                    n_digit = '0;
                    n_state = DV_PREP;
                end
            end
            DV_PREP: begin
                sub_a   = r_total;
                sub_b   = r_rem;
                n_diff  = sub[W-1:0];
                n_acc   = '0;
                n_cnt   = '0;
                n_d     = '0;
                n_state = DV_STEP;
            end
            DV_STEP: begin
                sub_a = r_acc;
                sub_b = r_diff;
                if (!borrow) begin
                    acc_step = sub[W-1:0];
                    d_step   = r_d + DIGIT_W'(1);
                end
                n_acc = acc_step;
                n_d   = d_step;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(DIGIT_STEPS - 1)) begin
                    n_rem = acc_step;
                    if (r_digit == 2'd2) begin
                        n_whole  = ({3'b000, r_d0} << 3) + ({3'b000, r_d0} << 1)
                                 + {3'b000, r_d1};
                        n_tenths = d_step;
                        n_done   = 1'b1;
                        n_state  = DV_IDLE;
                    end else begin
                        if (r_digit == 2'd0) begin
                            n_d0 = d_step;
                        end else begin
                            n_d1 = d_step;
                        end
                        n_digit = r_digit + 2'd1;
                        n_state = DV_PREP;
                    end
                end
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    assign o_stat.done   = r_done;
    assign o_stat.whole  = r_whole;
    assign o_stat.tenths = r_tenths;

endmodule

@@ rtl/core/task_time_load_profiler_unit.sv @@
// Per-task load profiler.
// Command channel: present i_func, i_task_id and i_timer_value with start;
// a word is taken at the clock edge where start is high and busy is low.
// Enter, exit and window end leave busy low.
// A report in a closed window raises busy and, per task, emits one result
// word on o_valid for a single cycle: task, whole percent, tenths digit,
// and o_last on the final task. A report in an open window does nothing.
// Report sequence: the sequencer first sums the accumulators, then for
// each task runs the shared subtractor through ten compare-subtract
// steps for each of three digits; a zero total or a clamped share skips
// the digit steps. Result words follow in task order, the last one as
// busy drops.
// The receiver cannot stall; each result is shown exactly once.
// Synchronous reset clears accumulators, stamp and window flag and
// returns the sequencer to idle.
module task_time_load_profiler_unit
    import ttlp_pkg::*;
#(
    parameter int NUM_TASKS   = 4,
    parameter int TIMER_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [TASK_W-1:0]   i_task_id,
    input  logic [STAMP_W-1:0]  i_timer_value,
    output logic                o_valid,
    output logic [TASK_W-1:0]   o_report_task,
    output logic [WHOLE_W-1:0]  o_percent_whole,
    output logic [TENTHS_W-1:0] o_percent_tenths,
    output logic                o_last
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TASKS - 1);

    t_state r_state, n_state;
    logic [TIMER_WIDTH-1:0] r_acc [NUM_TASKS];
    logic [TIMER_WIDTH-1:0] r_stamp, n_stamp;
    logic r_closed, n_closed;
    logic [TIMER_WIDTH-1:0] r_total, n_total;
    logic [IW-1:0] r_idx, n_idx;
    logic r_valid, n_valid;
    logic [TASK_W-1:0] r_task, n_task;
    logic [WHOLE_W-1:0] r_whole, n_whole;
    logic [TENTHS_W-1:0] r_tenths, n_tenths;
    logic r_last, n_last;

    logic [TIMER_WIDTH-1:0] stamp;
    logic [IW-1:0] rd_addr;
    logic [TIMER_WIDTH-1:0] rd_data;
    logic acc_we, acc_clr;
    logic [TIMER_WIDTH-1:0] acc_wdata;
    logic task_ok;
    logic div_start;
    t_div_stat div_stat;

    assign stamp   = TIMER_WIDTH'(i_timer_value);
    assign task_ok = (32'(i_task_id) < NUM_TASKS);
    assign rd_addr = (r_state == ST_IDLE) ? IW'(i_task_id) : r_idx;
    assign rd_data = r_acc[rd_addr];
    assign busy    = (r_state != ST_IDLE);

    ttlp_div #(
        .W (TIMER_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_t     (rd_data),
        .i_total (r_total),
        .o_stat  (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_acc[i] <= '0;
            end
        end else if (acc_clr) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_acc[i] <= '0;
            end
        end else if (acc_we) begin
            r_acc[rd_addr] <= acc_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_stamp  <= '0;
            r_closed <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_stamp  <= n_stamp;
            r_closed <= n_closed;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total  <= n_total;
        r_idx    <= n_idx;
        r_task   <= n_task;
        r_whole  <= n_whole;
        r_tenths <= n_tenths;
        r_last   <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_stamp   = r_stamp;
        n_closed  = r_closed;
        n_total   = r_total;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_task    = r_task;
        n_whole   = r_whole;
        n_tenths  = r_tenths;
        n_last    = r_last;
        acc_we    = 1'b0;
        acc_clr   = 1'b0;
        acc_wdata = rd_data + (stamp - r_stamp);
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (t_func'(i_func))
                        FUNC_ENTER: begin
                            n_stamp = stamp;
                        end
                        FUNC_EXIT: begin
                            acc_we  = !r_closed && task_ok;
                            n_stamp = stamp;
                        end
                        FUNC_WIN_END: begin
                            n_closed = 1'b1;
                            n_stamp  = '0;
                        end
                        FUNC_REPORT: begin
                            if (r_closed) begin
                                n_total = '0;
                                n_idx   = '0;
                                n_state = ST_SUM;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                // total wraps like the accumulators
                n_total = r_total + rd_data;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_SHARE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_SHARE: begin
                div_start = 1'b1;
                n_state   = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_stat.done) begin
                    n_valid  = 1'b1;
                    n_task   = TASK_W'(r_idx);
                    n_whole  = div_stat.whole;
                    n_tenths = div_stat.tenths;
                    n_last   = (r_idx == LAST_IDX);
                    if (r_idx == LAST_IDX) begin
                        acc_clr  = 1'b1;
                        n_closed = 1'b0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ST_SHARE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid          = r_valid;
    assign o_report_task    = r_task;
    assign o_percent_whole  = r_whole;
    assign o_percent_tenths = r_tenths;
    assign o_last           = r_last;

endmodule

@@ rtl/core/ttlp_checker.sv @@
`include "task_time_load_profiler_unit_macros.svh"

module ttlp_checker
    import ttlp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [FUNC_W-1:0]   i_func,
    input logic                o_valid,
    input logic [WHOLE_W-1:0]  o_percent_whole,
    input logic [TENTHS_W-1:0] o_percent_tenths,
    input logic                o_last
);

    logic share_ok;

    assign share_ok = (o_percent_tenths <= 4'd9) &&
                      ((o_percent_whole < WHOLE_FULL) ||
                       ((o_percent_whole == WHOLE_FULL) && (o_percent_tenths == 4'd0)));

    // share never above full, tenths a single digit
    `TTLP_ASSERT_IMP(a_share_range, o_valid, share_ok)

    // final word of a report comes as the block goes idle
    `TTLP_ASSERT_IMP(a_last_idle, o_valid && o_last, !busy)

    // earlier words of a report come while still busy
    `TTLP_ASSERT_IMP(a_mid_busy, o_valid && !o_last, busy)

    // only a report can raise busy
    `TTLP_ASSERT_NXT(a_event_short, start && !busy && (i_func != FUNC_REPORT), !busy)

endmodule

bind task_time_load_profiler_unit ttlp_checker u_ttlp_checker (.*);

@@ tb/task_time_load_profiler_unit_tb.sv @@
`default_nettype none

module task_time_load_profiler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttlp_pkg::*;

    localparam int N_TASKS        = 4;
    localparam int TARGET_WORDS   = 450;
    localparam int SHOWN_MISMATCH = 10;
    localparam int MAX_GAP        = 10;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 300;

    typedef struct {
        t_func              func;
        logic [TASK_W-1:0]  task_id;
        logic [STAMP_W-1:0] stamp;
        int                 gap;
    } t_event_word;

    typedef struct packed {
        logic [TASK_W-1:0]   report_task;
        logic [WHOLE_W-1:0]  whole;
        logic [TENTHS_W-1:0] tenths;
        logic                last;
    } t_share;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                start            = 1'b0;
    logic [FUNC_W-1:0]   i_func           = '0;
    logic [TASK_W-1:0]   i_task_id        = '0;
    logic [STAMP_W-1:0]  i_timer_value    = '0;
    logic                busy;
    logic                o_valid;
    logic [TASK_W-1:0]   o_report_task;
    logic [WHOLE_W-1:0]  o_percent_whole;
    logic [TENTHS_W-1:0] o_percent_tenths;
    logic                o_last;

    t_event_word         event_q[$];
    t_share              share_q[$];

    // mirror of the block state
    logic [STAMP_W-1:0]  busy_time[N_TASKS] = '{default: '0};
    logic [STAMP_W-1:0]  mark_stamp  = '0;
    logic                window_shut = 1'b0;

    bit                  word_taken   = 1'b0;
    bit                  burst_mode   = 1'b0;
    int                  gap_cnt      = 0;
    int                  words_queued = 0;
    int                  words_taken  = 0;
    int                  reports_seen = 0;
    int                  shares_seen  = 0;
    int                  mismatch_cnt = 0;

    task_time_load_profiler_unit #(
        .NUM_TASKS   (N_TASKS),
        .TIMER_WIDTH (STAMP_W)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_task_id        (i_task_id),
        .i_timer_value    (i_timer_value),
        .o_valid          (o_valid),
        .o_report_task    (o_report_task),
        .o_percent_whole  (o_percent_whole),
        .o_percent_tenths (o_percent_tenths),
        .o_last           (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // floor(t*1000/total), 0 for an empty window, clamped to a full share
    function automatic logic [9:0] share_permille(input logic [STAMP_W-1:0] t,
                                                  input logic [STAMP_W-1:0] total);
        logic [63:0] scaled;
        if (total == '0) return 10'd0;
        if (t >= total) return 10'd1000;
        scaled = ({32'd0, t} * 64'd1000) / {32'd0, total};
        return scaled[9:0];
    endfunction

    task automatic predict_event(input t_event_word w);
        logic [STAMP_W-1:0] total;
        logic [9:0]         pm;
        t_share             s;
        case (w.func)
            FUNC_ENTER: begin
                mark_stamp = w.stamp;
            end
            FUNC_EXIT: begin
                if (!window_shut)
                    busy_time[w.task_id] = busy_time[w.task_id] + (w.stamp - mark_stamp);
                mark_stamp = w.stamp;
            end
            FUNC_WIN_END: begin
                window_shut = 1'b1;
                mark_stamp  = '0;
            end
            FUNC_REPORT: begin
                if (window_shut) begin
                    total = '0;
                    for (int i = 0; i < N_TASKS; i++) total = total + busy_time[i];
                    for (int i = 0; i < N_TASKS; i++) begin
                        pm            = share_permille(busy_time[i], total);
                        s.report_task = TASK_W'(i);
                        s.whole       = WHOLE_W'(pm / 10);
                        s.tenths      = TENTHS_W'(pm % 10);
                        s.last        = (i == N_TASKS - 1);
                        share_q.push_back(s);
                    end
                    for (int i = 0; i < N_TASKS; i++) busy_time[i] = '0;
                    window_shut = 1'b0;
                    reports_seen++;
                end
            end
        endcase
    endtask

    // driver
    always @(negedge i_clk) begin
        t_event_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !word_taken) begin
            // word still waiting for the block
        end else if (event_q.size() == 0) begin
            start <= 1'b0;
        end else if (gap_cnt < event_q[0].gap) begin
            gap_cnt++;
            start <= 1'b0;
        end else begin
            w = event_q.pop_front();
            gap_cnt = 0;
            i_func        <= w.func;
            i_task_id     <= w.task_id;
            i_timer_value <= w.stamp;
            start         <= 1'b1;
        end
        word_taken = 1'b0;
    end

    // acceptance and result monitor
    always @(posedge i_clk) begin
        t_event_word w;
        t_share      want;
        t_share      got;
        if (i_rst_n && start && !busy) begin
            word_taken = 1'b1;
            words_taken++;
            w.func    = t_func'(i_func);
            w.task_id = i_task_id;
            w.stamp   = i_timer_value;
            w.gap     = 0;
            predict_event(w);
        end
        if (i_rst_n && o_valid) begin
            got = '{o_report_task, o_percent_whole, o_percent_tenths, o_last};
            if (share_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= SHOWN_MISMATCH)
                    $display("unexpected result word: task %0d share %0d.%0d last %0b",
                             got.report_task, got.whole, got.tenths, got.last);
            end else begin
                want = share_q.pop_front();
                shares_seen++;
                if (got.report_task != want.report_task || got.whole != want.whole ||
                    got.tenths != want.tenths || got.last != want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOWN_MISMATCH) begin
                        $display("share mismatch: expected task %0d %0d.%0d last %0b",
                                 want.report_task, want.whole, want.tenths, want.last);
                        $display("                got task %0d %0d.%0d last %0b",
                                 got.report_task, got.whole, got.tenths, got.last);
                    end
                end
            end
        end
    end

    task automatic push_word(input t_func f, input logic [TASK_W-1:0] id,
                             input logic [STAMP_W-1:0] ts);
        t_event_word w;
        w.func    = f;
        w.task_id = id;
        w.stamp   = ts;
        w.gap     = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        event_q.push_back(w);
        words_queued++;
    endtask

    function automatic logic [TASK_W-1:0] rand_id();
        return TASK_W'($urandom_range(0, 3));
    endfunction

    function automatic logic [STAMP_W-1:0] draw_duration();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return STAMP_W'($urandom_range(1, 50));
            2:       return STAMP_W'($urandom_range(1, 100000));
            3:       return STAMP_W'($urandom_range(1, 32'h0fff_ffff));
            default: return STAMP_W'($urandom);
        endcase
    endfunction

    // enter/exit pairs, then window end and report, with stray report, exit and window-end words mixed in at random
    task automatic random_window();
        logic [STAMP_W-1:0] ts;
        logic [TASK_W-1:0]  id;
        int                 pairs;
        ts    = $urandom;
        pairs = $urandom_range(1, 8);
        repeat (pairs) begin
            id = TASK_W'($urandom_range(0, N_TASKS - 1));
            push_word(FUNC_ENTER, id, ts);
            ts = ts + draw_duration();
            push_word(FUNC_EXIT, id, ts);
            if ($urandom_range(0, 4) == 0) ts = ts + STAMP_W'($urandom_range(0, 5000));
        end
        if ($urandom_range(0, 7) == 0) push_word(FUNC_REPORT, rand_id(), $urandom);
        push_word(FUNC_WIN_END, rand_id(), $urandom);
        if ($urandom_range(0, 5) == 0) push_word(FUNC_EXIT, rand_id(), $urandom);
        if ($urandom_range(0, 7) == 0) push_word(FUNC_WIN_END, rand_id(), $urandom);
        push_word(FUNC_REPORT, rand_id(), $urandom);
    endtask

    initial begin
        int waited;

        // directed part
        push_word(FUNC_REPORT,  2'd0, 32'h0000_0000);
        push_word(FUNC_WIN_END, 2'd3, 32'hffff_ffff);
        push_word(FUNC_WIN_END, 2'd0, 32'h1234_5678);
        push_word(FUNC_REPORT,  2'd1, 32'h0000_0000);
        push_word(FUNC_REPORT,  2'd2, 32'hffff_ffff);
        push_word(FUNC_ENTER,   2'd0, 32'd0);
        push_word(FUNC_EXIT,    2'd0, 32'd100);
        push_word(FUNC_ENTER,   2'd1, 32'd100);
        push_word(FUNC_EXIT,    2'd1, 32'd400);
        push_word(FUNC_ENTER,   2'd2, 32'hffff_fff0);
        push_word(FUNC_EXIT,    2'd2, 32'h0000_0010);
        push_word(FUNC_ENTER,   2'd3, 32'd0);
        push_word(FUNC_EXIT,    2'd3, 32'hffff_ffff);
        push_word(FUNC_WIN_END, 2'd1, 32'd0);
        push_word(FUNC_EXIT,    2'd1, 32'd12345);
        push_word(FUNC_REPORT,  2'd3, 32'd0);
        push_word(FUNC_ENTER,   2'd2, 32'd7);
        push_word(FUNC_EXIT,    2'd2, 32'd1007);
        push_word(FUNC_WIN_END, 2'd2, 32'd0);
        push_word(FUNC_REPORT,  2'd0, 32'd0);

        // random part
        while (words_queued < TARGET_WORDS) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    push_word(t_func'($urandom_range(0, 3)), rand_id(), $urandom);
            end else begin
                random_window();
            end
        end

        do @(posedge i_clk); while (event_q.size() != 0 || words_taken < words_queued);
        waited = 0;
        while (share_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("load profiler run: %0d words sent, %0d granted reports",
                 words_taken, reports_seen);
        $display("%0d share words checked, %0d mismatches, %0d share words never seen",
                 shares_seen, mismatch_cnt, share_q.size());
        if (mismatch_cnt == 0 && share_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
